// File: src/nearest_point_within_radius_core_macros.svh
// assertion helpers used by the checker of this block
`ifndef NEAREST_POINT_WITHIN_RADIUS_CORE_MACROS_SVH
`define NEAREST_POINT_WITHIN_RADIUS_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/npr_pkg.sv
`timescale 1ns / 1ps
package npr_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 21;          // |dx| below 2^21 is the only useful range
  localparam int SQ_W    = 2 * MAG_W;
  localparam int D2_W    = SQ_W + 1;
  localparam int SID_W   = 31;
  localparam int SIDX_W  = 16;
  localparam int HIT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 2'd1;

  localparam logic [CFG_W-1:0] RADIUS_RESET = 16'd100;
  localparam logic [CFG_W-1:0] STOP_RESET   = 16'd5;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               filtered;
    logic               no_coord;
  } point_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    point_t            pt;
  } tbl_wr_t;

  typedef struct packed {
    logic              street_we;
    logic              hits_we;
    logic [ADDR_W-1:0] addr;
    logic [SID_W-1:0]  sid;
    logic [SIDX_W-1:0] sidx;
    logic [HIT_W-1:0]  hits;
  } info_req_t;

  typedef struct packed {
    logic [SID_W-1:0]  sid;
    logic [SIDX_W-1:0] sidx;
    logic [HIT_W-1:0]  hits;
  } info_rd_t;

endpackage

// File: src/npr_table.sv
`timescale 1ns / 1ps
module npr_table import npr_pkg::*; (
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output point_t            rd_pt_r
);

  point_t mem_r [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.pt;
    end
    rd_pt_r <= mem_r[rd_addr];
  end

endmodule

// File: src/npr_info.sv
`timescale 1ns / 1ps
module npr_info import npr_pkg::*; (
  input  logic      clk,
  input  info_req_t req,
  output info_rd_t  rd_r
);

  logic [SID_W+SIDX_W-1:0] street_r [MAX_POINTS];
  logic [HIT_W-1:0]        hits_r   [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (req.street_we) begin
      street_r[req.addr] <= {req.sid, req.sidx};
    end
    if (req.hits_we) begin
      hits_r[req.addr] <= req.hits;
    end
    {rd_r.sid, rd_r.sidx} <= street_r[req.addr];
    rd_r.hits <= hits_r[req.addr];
  end

endmodule

// File: src/npr_sq.sv
`timescale 1ns / 1ps
module npr_sq import npr_pkg::*; (
  input  logic             clk,
  input  logic [MAG_W-1:0] a,
  input  logic [MAG_W-1:0] b,
  output logic [SQ_W-1:0]  a_sq_r,
  output logic [SQ_W-1:0]  b_sq_r
);

  always_ff @(posedge clk) begin
    a_sq_r <= SQ_W'(a) * SQ_W'(a);
    b_sq_r <= SQ_W'(b) * SQ_W'(b);
  end

endmodule

// File: src/nearest_point_within_radius_core.sv
`timescale 1ns / 1ps
// Nearest reference point within a radius. A load transaction (cmd 0) appends one point to a
// table of MAX_POINTS entries; loads into a full table are dropped. A query (cmd 1) scans the
// stored points in load order, one table read per cycle through a shared distance unit (abs
// difference, squarer, compare), and returns the nearest point strictly inside search_radius,
// ending early once a kept point lies within stop_distance. A query lasts longer the more
// points it scans, as the point table has a single read port; a query without coordinates
// skips the scan. in_ready is low while a query is in progress. No clearing pass is needed
// after reset: the fill count guards the table. Write cfg registers only while the block
// is idle.
module nearest_point_within_radius_core import npr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic signed [31:0]   in_x_coord,
  input  logic signed [31:0]   in_y_coord,
  input  logic                 in_no_coordinate,
  input  logic                 in_filtered,
  input  logic [SID_W-1:0]     in_street_id,
  input  logic [SIDX_W-1:0]    in_street_index,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic                 out_invalid_query,
  output logic [ADDR_W-1:0]    out_nearest_slot,
  output logic [SID_W-1:0]     out_nearest_street_id,
  output logic [SIDX_W-1:0]    out_nearest_street_index,
  output logic [HIT_W-1:0]     out_hit_count
);

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_SETUP      = 8'b0000_0010,
    ST_SETUP_WAIT = 8'b0000_0100,
    ST_SCAN       = 8'b0000_1000,
    ST_DRAIN      = 8'b0001_0000,
    ST_LOOKUP     = 8'b0010_0000,
    ST_UPDATE     = 8'b0100_0000,
    ST_RESULT     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   radius_r, stop_cfg_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [COORD_W-1:0] qx_r, qy_r;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;

  // scan pipeline
  logic              rd_vld_r, ab_vld_r, sq_vld_r;
  logic [ADDR_W-1:0] rd_idx_r, ab_idx_r, sq_idx_r;
  logic [MAG_W-1:0]  ab_dx_r, ab_dy_r;

  logic [D2_W-1:0]   best_r, best_nxt, stop_d2_r, stop_d2_nxt;
  logic [ADDR_W-1:0] best_idx_r, best_idx_nxt;
  logic              found_r, found_nxt, done_r, done_nxt;

  // pending result
  logic              res_found_r, res_found_nxt, res_inv_r, res_inv_nxt;
  logic [ADDR_W-1:0] res_slot_r, res_slot_nxt;
  logic [SID_W-1:0]  res_sid_r, res_sid_nxt;
  logic [SIDX_W-1:0] res_sidx_r, res_sidx_nxt;
  logic [HIT_W-1:0]  res_hits_r, res_hits_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_inv_r;
  logic [ADDR_W-1:0] out_slot_r;
  logic [SID_W-1:0]  out_sid_r;
  logic [SIDX_W-1:0] out_sidx_r;
  logic [HIT_W-1:0]  out_hits_r;
  logic              out_load;

  tbl_wr_t           tbl_wr;
  point_t            tbl_rd;
  info_req_t         info_req;
  info_rd_t          info_rd;

  logic              in_accept, load_ok, issue;
  logic [COORD_W:0]  dxp, dxn, dyp, dyn, adx, ady;
  logic              qualify;
  logic [MAG_W-1:0]  sq_a, sq_b;
  logic [SQ_W-1:0]   a_sq, b_sq;
  logic [D2_W-1:0]   d2;
  logic              take;
  logic [HIT_W-1:0]  hits_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign load_ok   = in_accept && (in_cmd == CMD_LOAD) && (count_r < CNT_W'(MAX_POINTS));
  assign issue     = (state_r == ST_SCAN) && (scan_idx_r < count_r) && !done_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= RADIUS_RESET;
      stop_cfg_r <= STOP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEARCH_RADIUS: radius_r   <= cfg_wdata;
        REG_STOP_DISTANCE: stop_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // point table
  always_comb begin
    tbl_wr.en          = load_ok;
    tbl_wr.addr        = count_r[ADDR_W-1:0];
    tbl_wr.pt.x        = in_x_coord;
    tbl_wr.pt.y        = in_y_coord;
    tbl_wr.pt.filtered = in_filtered;
    tbl_wr.pt.no_coord = in_no_coordinate;
  end

  npr_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (scan_idx_r[ADDR_W-1:0]),
    .rd_pt_r (tbl_rd)
  );

  // street info and hit counters
  assign hits_inc = (info_rd.hits == {HIT_W{1'b1}}) ? info_rd.hits : info_rd.hits + 1'b1;

  always_comb begin
    info_req.street_we = load_ok;
    info_req.hits_we   = load_ok || (state_r == ST_UPDATE);
    info_req.addr      = load_ok ? count_r[ADDR_W-1:0] : best_idx_r;
    info_req.sid       = in_street_id;
    info_req.sidx      = in_street_index;
    info_req.hits      = load_ok ? '0 : hits_inc;
  end

  npr_info u_info (
    .clk  (clk),
    .req  (info_req),
    .rd_r (info_rd)
  );

  // abs difference stage, far points dropped here
  always_comb begin
    dxp = {qx_r[COORD_W-1], qx_r} - {tbl_rd.x[COORD_W-1], tbl_rd.x};
    dxn = {tbl_rd.x[COORD_W-1], tbl_rd.x} - {qx_r[COORD_W-1], qx_r};
    dyp = {qy_r[COORD_W-1], qy_r} - {tbl_rd.y[COORD_W-1], tbl_rd.y};
    dyn = {tbl_rd.y[COORD_W-1], tbl_rd.y} - {qy_r[COORD_W-1], qy_r};
    adx = dxp[COORD_W] ? dxn : dxp;
    ady = dyp[COORD_W] ? dyn : dyp;
    qualify = rd_vld_r && !tbl_rd.no_coord && !tbl_rd.filtered &&
              !(|adx[COORD_W:MAG_W]) && !(|ady[COORD_W:MAG_W]);
  end

  // the squarer also turns the two thresholds into squared form at query start
  assign sq_a = (state_r == ST_SETUP) ? {1'b0, radius_r, 4'b0000}   : ab_dx_r;
  assign sq_b = (state_r == ST_SETUP) ? {1'b0, stop_cfg_r, 4'b0000} : ab_dy_r;

  npr_sq u_sq (
    .clk    (clk),
    .a      (sq_a),
    .b      (sq_b),
    .a_sq_r (a_sq),
    .b_sq_r (b_sq)
  );

  assign d2   = {1'b0, a_sq} + {1'b0, b_sq};
  assign take = sq_vld_r && !done_r && (d2 < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      ab_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      ab_vld_r <= qualify;
      sq_vld_r <= ab_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r[ADDR_W-1:0];
    ab_idx_r <= rd_idx_r;
    sq_idx_r <= ab_idx_r;
    ab_dx_r  <= adx[MAG_W-1:0];
    ab_dy_r  <= ady[MAG_W-1:0];
    if (in_accept) begin
      qx_r <= in_x_coord;
      qy_r <= in_y_coord;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    best_nxt      = best_r;
    stop_d2_nxt   = stop_d2_r;
    best_idx_nxt  = best_idx_r;
    found_nxt     = found_r;
    done_nxt      = done_r;
    res_found_nxt = res_found_r;
    res_inv_nxt   = res_inv_r;
    res_slot_nxt  = res_slot_r;
    res_sid_nxt   = res_sid_r;
    res_sidx_nxt  = res_sidx_r;
    res_hits_nxt  = res_hits_r;
    out_load      = 1'b0;

    if (take) begin
      best_nxt     = d2;
      best_idx_nxt = sq_idx_r;
      found_nxt    = 1'b1;
      if (d2 <= stop_d2_r) begin
        done_nxt = 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (load_ok) begin
          count_nxt = count_r + 1'b1;
        end
        if (in_accept && (in_cmd == CMD_QUERY)) begin
          res_found_nxt = 1'b0;
          res_slot_nxt  = '0;
          res_sid_nxt   = '0;
          res_sidx_nxt  = '0;
          res_hits_nxt  = '0;
          if (in_no_coordinate) begin
            res_inv_nxt = 1'b1;
            state_nxt   = ST_RESULT;
          end else begin
            res_inv_nxt = 1'b0;
            state_nxt   = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        state_nxt = ST_SETUP_WAIT;
      end
      ST_SETUP_WAIT: begin
        best_nxt     = {1'b0, a_sq};
        stop_d2_nxt  = {1'b0, b_sq};
        found_nxt    = 1'b0;
        done_nxt     = 1'b0;
        scan_idx_nxt = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait until the last point has left the compare stage
        if (!rd_vld_r && !ab_vld_r && !sq_vld_r) begin
          state_nxt = found_r ? ST_LOOKUP : ST_RESULT;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        res_found_nxt = 1'b1;
        res_slot_nxt  = best_idx_r;
        res_sid_nxt   = info_rd.sid;
        res_sidx_nxt  = info_rd.sidx;
        res_hits_nxt  = hits_inc;
        state_nxt     = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      found_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    best_r      <= best_nxt;
    stop_d2_r   <= stop_d2_nxt;
    best_idx_r  <= best_idx_nxt;
    res_found_r <= res_found_nxt;
    res_inv_r   <= res_inv_nxt;
    res_slot_r  <= res_slot_nxt;
    res_sid_r   <= res_sid_nxt;
    res_sidx_r  <= res_sidx_nxt;
    res_hits_r  <= res_hits_nxt;
    if (out_load) begin
      out_found_r <= res_found_r;
      out_inv_r   <= res_inv_r;
      out_slot_r  <= res_slot_r;
      out_sid_r   <= res_sid_r;
      out_sidx_r  <= res_sidx_r;
      out_hits_r  <= res_hits_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_found                = out_found_r;
  assign out_invalid_query        = out_inv_r;
  assign out_nearest_slot         = out_slot_r;
  assign out_nearest_street_id    = out_sid_r;
  assign out_nearest_street_index = out_sidx_r;
  assign out_hit_count            = out_hits_r;

endmodule

// File: src/npr_checker.sv
`timescale 1ns / 1ps
`include "nearest_point_within_radius_core_macros.svh"
module npr_checker import npr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic              out_invalid_query,
  input logic [ADDR_W-1:0] out_nearest_slot,
  input logic [SID_W-1:0]  out_nearest_street_id,
  input logic [HIT_W-1:0]  out_hit_count
);

  // a query keeps the block busy for at least the next cycle
  `NPR_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && in_ready && (in_cmd == CMD_QUERY), !in_ready, "query did not hold off input")

  `NPR_ASSERT_NOW(a_invalid_empty, clk, rst_n, out_valid && out_invalid_query, !out_found && (out_hit_count == '0) && (out_nearest_slot == '0), "invalid query carries a match")

  // a reported match has been counted at least once
  `NPR_ASSERT_NOW(a_found_counted, clk, rst_n, out_valid && out_found, (out_hit_count != '0) && !out_invalid_query, "match without hit count")

  `NPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_nearest_street_id) && $stable(out_hit_count), "stalled result changed")

endmodule

bind nearest_point_within_radius_core npr_checker u_npr_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import npr_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic [63:0] FAR_SPAN = 64'd1 << MAG_W;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [COORD_W-1:0] HOME_X = 32'd16000;
  localparam logic [COORD_W-1:0] HOME_Y = 32'd16000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               no_coord;
    logic               filtered;
    logic [SID_W-1:0]   sid;
    logic [SIDX_W-1:0]  sidx;
  } point_item_t;

  typedef struct packed {
    logic              found;
    logic              invalid;
    logic [ADDR_W-1:0] slot;
    logic [SID_W-1:0]  sid;
    logic [SIDX_W-1:0] sidx;
    logic [HIT_W-1:0]  hits;
  } search_result_t;

  // mirror of the point table plus the answers still owed by the block
  class point_table_model;
    logic [COORD_W-1:0] px    [MAX_POINTS];
    logic [COORD_W-1:0] py    [MAX_POINTS];
    logic [SID_W-1:0]   psid  [MAX_POINTS];
    logic [SIDX_W-1:0]  psidx [MAX_POINTS];
    logic               pskip [MAX_POINTS];
    logic [HIT_W-1:0]   hits  [MAX_POINTS];
    int                 fill;
    logic [CFG_W-1:0]   radius;
    logic [CFG_W-1:0]   stop_dist;
    search_result_t     answers_due [$];
    int                 errors;

    function new();
      fill = 0;
      errors = 0;
      radius = RADIUS_RESET;
      stop_dist = STOP_RESET;
      foreach (hits[i]) hits[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_SEARCH_RADIUS) radius = val;
      else if (idx == REG_STOP_DISTANCE) stop_dist = val;
    endfunction

    static function logic [63:0] abs_diff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return {31'b0, d[COORD_W] ? (~d + 1'b1) : d};
    endfunction

    function void take_item(point_item_t it);
      search_result_t   res;
      logic [63:0]      best_d2, stop_d2, dx, dy, d2;
      logic [CFG_W+3:0] r16, s16;
      int               best, i;
      bit               got_one;
      if (it.cmd == CMD_LOAD) begin
        if (fill < MAX_POINTS) begin
          px[fill] = it.x;
          py[fill] = it.y;
          psid[fill] = it.sid;
          psidx[fill] = it.sidx;
          pskip[fill] = it.no_coord | it.filtered;
          hits[fill] = '0;
          fill++;
        end
        return;
      end
      res = '0;
      if (it.no_coord) begin
        res.invalid = 1'b1;
        answers_due.push_back(res);
        return;
      end
      r16 = {radius, 4'b0};
      s16 = {stop_dist, 4'b0};
      best_d2 = 64'(r16) * 64'(r16);
      stop_d2 = 64'(s16) * 64'(s16);
      best = 0;
      got_one = 0;
      for (i = 0; i < fill; i++) begin
        if (pskip[i]) continue;
        dx = abs_diff(it.x, px[i]);
        dy = abs_diff(it.y, py[i]);
        // too far to square, no legal radius reaches it
        if (dx >= FAR_SPAN || dy >= FAR_SPAN) continue;
        d2 = dx * dx + dy * dy;
        if (d2 < best_d2) begin
          best_d2 = d2;
          best = i;
          got_one = 1;
          if (d2 <= stop_d2) break;
        end
      end
      if (got_one) begin
        if (hits[best] != '1) hits[best]++;
        res.found = 1'b1;
        res.slot = ADDR_W'(best);
        res.sid = psid[best];
        res.sidx = psidx[best];
        res.hits = hits[best];
      end
      answers_due.push_back(res);
    endfunction

    function void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        if (errors <= 50)
          $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want_v, got_v);
      end
    endfunction

    function void check_answer(search_result_t got);
      search_result_t want;
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: result with none pending: expected nothing actual %h", $time, got);
        return;
      end
      want = answers_due.pop_front();
      check_field("found", want.found, got.found);
      check_field("invalid_query", want.invalid, got.invalid);
      check_field("nearest_slot", want.slot, got.slot);
      check_field("nearest_street_id", want.sid, got.sid);
      check_field("nearest_street_index", want.sidx, got.sidx);
      check_field("hit_count", want.hits, got.hits);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic signed [31:0]   in_x_coord;
  logic signed [31:0]   in_y_coord;
  logic                 in_no_coordinate;
  logic                 in_filtered;
  logic [SID_W-1:0]     in_street_id;
  logic [SIDX_W-1:0]    in_street_index;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_found;
  logic                 out_invalid_query;
  logic [ADDR_W-1:0]    out_nearest_slot;
  logic [SID_W-1:0]     out_nearest_street_id;
  logic [SIDX_W-1:0]    out_nearest_street_index;
  logic [HIT_W-1:0]     out_hit_count;

  point_table_model sb;
  rx_mode_e         rx_mode;
  int               tx_max_gap;
  int               burst_left;
  int               spread;
  int               rx_tick;
  int               quiet_cycles;
  logic [COORD_W-1:0] cx, cy;

  nearest_point_within_radius_core DUT (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_cmd                   (in_cmd),
    .in_x_coord               (in_x_coord),
    .in_y_coord               (in_y_coord),
    .in_no_coordinate         (in_no_coordinate),
    .in_filtered              (in_filtered),
    .in_street_id             (in_street_id),
    .in_street_index          (in_street_index),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_found                (out_found),
    .out_invalid_query        (out_invalid_query),
    .out_nearest_slot         (out_nearest_slot),
    .out_nearest_street_id    (out_nearest_street_id),
    .out_nearest_street_index (out_nearest_street_index),
    .out_hit_count            (out_hit_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver back-pressure
  initial begin
    out_ready = 1'b0;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      rx_tick++;
      case (rx_mode)
        RX_ALWAYS:   out_ready = 1'b1;
        RX_RANDOM:   out_ready = ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ready = ((rx_tick % 7) < 3);
        default:     out_ready = ($urandom_range(0, 11) == 0);
      endcase
    end
  end

  // transaction monitors and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid && in_ready)
        sb.take_item({in_cmd, in_x_coord, in_y_coord, in_no_coordinate, in_filtered,
                      in_street_id, in_street_index});
      if (out_valid && out_ready)
        sb.check_answer({out_found, out_invalid_query, out_nearest_slot,
                         out_nearest_street_id, out_nearest_street_index, out_hit_count});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push(input point_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_cmd = it.cmd;
    in_x_coord = it.x;
    in_y_coord = it.y;
    in_no_coordinate = it.no_coord;
    in_filtered = it.filtered;
    in_street_id = it.sid;
    in_street_index = it.sidx;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic load_pt(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                         input logic nc, input logic filt,
                         input logic [SID_W-1:0] sid, input logic [SIDX_W-1:0] sidx);
    push('{CMD_LOAD, x, y, nc, filt, sid, sidx});
  endtask

  task automatic query_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                          input logic nc);
    push('{CMD_QUERY, x, y, nc, 1'($urandom), SID_W'($urandom), SIDX_W'($urandom)});
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    burst_left = 0;
    while (sb.answers_due.size() != 0) @(negedge clk);
    // a trailing load may still be in flight
    repeat (16) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic point_item_t random_item(bit want_query);
    point_item_t it;
    int          slot;
    it.cmd = want_query ? CMD_QUERY : CMD_LOAD;
    it.x = cx + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
    it.y = cy + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
    if ($urandom_range(0, 9) == 0) it.x = $urandom;
    if ($urandom_range(0, 9) == 0) it.y = $urandom;
    // aim many queries close to a stored point
    if (want_query && sb.fill > 0 && $urandom_range(0, 2) != 0) begin
      slot = $urandom_range(0, sb.fill - 1);
      it.x = sb.px[slot] + 32'($urandom_range(0, 2000)) - 32'd1000;
      it.y = sb.py[slot] + 32'($urandom_range(0, 2000)) - 32'd1000;
    end
    it.no_coord = ($urandom_range(0, 9) == 0);
    it.filtered = want_query ? 1'($urandom) : ($urandom_range(0, 6) == 0);
    it.sid = SID_W'($urandom);
    it.sidx = SIDX_W'($urandom);
    return it;
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] rad, input logic [CFG_W-1:0] stp,
                           input int count);
    int n;
    wait_drained();
    set_reg(REG_SEARCH_RADIUS, rad);
    set_reg(REG_STOP_DISTANCE, stp);
    tx_max_gap = $urandom_range(0, 6);
    rx_mode = rx_mode_e'($urandom_range(0, 3));
    cx = $urandom;
    cy = $urandom;
    case ($urandom_range(0, 2))
      0: spread = 200;
      1: spread = 2000;
      default: spread = 30000;
    endcase
    for (n = 0; n < count; n++) push(random_item($urandom_range(0, 9) < 6));
  endtask

  initial begin
    point_item_t late;
    point_item_t probe;
    int          k;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_LOAD;
    in_x_coord = '0;
    in_y_coord = '0;
    in_no_coordinate = 1'b0;
    in_filtered = 1'b0;
    in_street_id = '0;
    in_street_index = '0;
    rx_mode = RX_RANDOM;
    tx_max_gap = 3;
    burst_left = 0;
    spread = 2000;
    cx = '0;
    cy = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset register values
    query_at(32'd0, 32'd0, 1'b0);
    query_at(32'd0, 32'd0, 1'b1);
    load_pt(HOME_X, HOME_Y, 1'b0, 1'b0, '0, '0);
    load_pt(32'd0, 32'd0, 1'b0, 1'b1, '1, '1);
    load_pt(32'd0, 32'd0, 1'b1, 1'b0, 31'd3, 16'd3);
    load_pt(32'd320, 32'd0, 1'b0, 1'b0, 31'd11, 16'd1);
    load_pt(-32'sd320, 32'd0, 1'b0, 1'b0, 31'd12, 16'd2);
    // would alias to a near point if the difference got truncated
    load_pt(32'h0020_0028, 32'd0, 1'b0, 1'b0, 31'd13, 16'd3);
    load_pt(32'd0, 32'hFFE0_0000, 1'b0, 1'b0, 31'd14, 16'd4);
    load_pt(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 31'h5555_5555, 16'hAAAA);
    load_pt(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 31'h2AAA_AAAA, 16'h5555);
    load_pt(HOME_X + 32'd80, HOME_Y, 1'b0, 1'b0, 31'd99, 16'd99);
    query_at(32'd0, 32'd0, 1'b0);
    query_at(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    query_at(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    query_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    query_at(HOME_X, HOME_Y - 32'd1600, 1'b0);
    query_at(HOME_X, HOME_Y + 32'd1599, 1'b0);
    query_at(HOME_X + 32'd80, HOME_Y, 1'b0);
    query_at(HOME_X + 32'd81, HOME_Y, 1'b0);

    // repeated hits on the first point, back to back
    wait_drained();
    set_reg(REG_SEARCH_RADIUS, '1);
    set_reg(REG_STOP_DISTANCE, '1);
    tx_max_gap = 0;
    rx_mode = RX_ALWAYS;
    repeat (6) query_at(HOME_X, HOME_Y, 1'b0);

    // random part over several register settings
    wait_drained();
    set_reg(REG_SPARE_2, CFG_W'($urandom));
    set_reg(REG_SPARE_3, CFG_W'($urandom));
    run_phase(16'd100, 16'd5, 14);
    run_phase(16'd0, 16'd7, 14);
    run_phase(16'hFFFF, 16'd0, 14);
    run_phase(16'd300, 16'd20, 14);
    run_phase(16'd2000, 16'd0, 14);
    run_phase(16'd40, 16'hFFFF, 14);
    run_phase(CFG_W'($urandom), CFG_W'($urandom_range(0, 40)), 14);

    // scans over every stored point, then a tighter radius
    wait_drained();
    set_reg(REG_SEARCH_RADIUS, '1);
    set_reg(REG_STOP_DISTANCE, '0);
    tx_max_gap = 0;
    rx_mode = RX_RANDOM;
    late = random_item(1'b0);
    late.no_coord = 1'b0;
    late.filtered = 1'b0;
    late.x = $urandom;
    late.y = $urandom;
    push(late);
    push(random_item(1'b0));
    probe = late;
    probe.cmd = CMD_QUERY;
    tx_max_gap = 2;
    push(probe);
    for (k = 0; k < 3; k++) push(random_item(1'b1));
    wait_drained();
    set_reg(REG_SEARCH_RADIUS, 16'd50);
    set_reg(REG_STOP_DISTANCE, 16'd3);
    rx_mode = RX_SPARSE;
    for (k = 0; k < 4; k++) push(random_item(1'b1));

    wait_drained();
    repeat (32) @(negedge clk);
    if (sb.errors == 0 && sb.answers_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
